>>> rtl/core/bzci_pkg.sv
package bzci_pkg;

   // operation codes carried in a request beat
   localparam logic [2:0] OP_LOAD  = 3'd0;
   localparam logic [2:0] OP_QUERY = 3'd1;
   localparam logic [2:0] OP_BUMP  = 3'd2;
   localparam logic [2:0] OP_PAR   = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_MATCH = 1'b1;

   // divider width: 23-bit by 34-bit product, sign included
   localparam int DIV_W     = 57;
   localparam int DIV_STEPS = 57;
   localparam int MUL_STEPS = 23;

   // basis points in Q16.8 to Q4.28: times 2^20 over 10000, i.e. times 2^16 over 625.
   // Split |b| = 625*q + r, then q*2^16 + floor(r*2^16/625); both steps by reciprocal.
   localparam logic [23:0] BP_BASE       = 24'd625;
   localparam logic [23:0] BP_RECIP      = 24'd13743896;  // ceil(2^33/625)
   localparam logic [24:0] BP_FRAC_RECIP = 25'd27487791;  // ceil(2^34/625)

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Q_FIRST,
      ST_Q_LAST,
      ST_Q_SCAN,
      ST_MUL,
      ST_QDIV_GO,
      ST_QDIV,
      ST_DELTA,
      ST_DREM,
      ST_DSCALE,
      ST_B_RD,
      ST_B_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic [22:0]             divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DIV_W-1:0] quotient;
   } div_rsp_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
      logic signed [31:0] r;
      if (v > 58'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -58'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/bzci_if.sv
interface bzci_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic [3:0]         pillar_index;
   logic [22:0]        time_point;
   logic signed [31:0] zero_value;
   logic signed [23:0] bump_amount;

   modport source (output valid, opcode, pillar_index, time_point, zero_value, bump_amount,
                   input ready);
   modport sink (input valid, opcode, pillar_index, time_point, zero_value, bump_amount,
                 output ready);
endinterface

interface bzci_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] rate;
   logic               status;

   modport source (output valid, rate, status, input ready);
   modport sink (input valid, rate, status, output ready);
endinterface

>>> rtl/core/bzci_div.sv
module bzci_div (
   input  logic                   clock,
   input  logic                   reset,
   input  bzci_pkg::div_req_type  div_req,
   output bzci_pkg::div_rsp_type  div_rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           neg_ff, neg_in;
   logic [5:0]                     cnt_ff, cnt_in;
   logic [22:0]                    rem_ff, rem_in;
   logic [22:0]                    dvs_ff, dvs_in;
   logic [bzci_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [23:0]                    shifted;
   logic [23:0]                    diff;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[bzci_pkg::DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[bzci_pkg::DIV_W-1];
         quo_in  = neg_in ? (~div_req.dividend + 1'b1) : div_req.dividend;
         rem_in  = '0;
         cnt_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[23]) begin
            rem_in = diff[22:0];
            quo_in = {quo_ff[bzci_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[22:0];
            quo_in = {quo_ff[bzci_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'(bzci_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   // restore sign: truncation toward zero
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

>>> rtl/core/bumped_zero_curve_interpolator.sv
// Sequence, from the accepting edge to the edge that raises rsp valid:
//   load, reset bumps, unused opcode: straight to the result.
//   query: flat below the first pillar, flat above the last, otherwise a scan of the pillars
//   with one table read per cycle, then a shift-add multiply and the serial divider.
//   Bump and parallel bump: scale the amount, then read and check the pillars one by one.
// One item at a time; the next beat is taken once the result is posted.
// Synchronous active-high reset clears bumps (valid bits), count to 1, handshake state.
module bumped_zero_curve_interpolator #(
   parameter int MAX_PILLARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata,
   bzci_req_if.sink    req_chan,
   bzci_rsp_if.source  rsp_chan
);

   localparam int AW = (MAX_PILLARS > 1) ? $clog2(MAX_PILLARS) : 1;
   localparam int NW = $clog2(MAX_PILLARS + 1);

   // table memories
   logic [22:0]        tenor_mem [MAX_PILLARS];
   logic signed [31:0] zero_mem  [MAX_PILLARS];
   logic signed [31:0] bump_mem  [MAX_PILLARS];
   logic [MAX_PILLARS-1:0] bvld_ff;

   logic [22:0]        tenor_rd_ff;
   logic signed [31:0] zero_rd_ff;
   logic signed [31:0] bump_rd_ff;
   logic               bvld_rd_ff;

   bzci_pkg::state_type state_ff, state_in;
   logic [4:0]          count_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_rate_ff;
   logic                rsp_status_ff;

   logic [2:0]          op_ff, op_in;
   logic [22:0]         t_ff, t_in;
   logic [NW-1:0]       idx_ff, idx_in;
   logic signed [31:0]  delta_ff, delta_in;
   logic [22:0]         lo_t_ff, lo_t_in;
   logic signed [32:0]  lo_v_ff, lo_v_in;
   logic [22:0]         den_ff, den_in;
   logic signed [bzci_pkg::DIV_W-1:0] mcand_ff, mcand_in;
   logic signed [bzci_pkg::DIV_W-1:0] acc_ff, acc_in;
   logic [22:0]         mplier_ff, mplier_in;
   logic [4:0]          mcnt_ff, mcnt_in;
   logic signed [31:0]  res_rate_ff, res_rate_in;
   logic                res_status_ff, res_status_in;
   logic                bneg_ff, bneg_in;
   logic [23:0]         bmag_ff, bmag_in;
   logic [13:0]         bq_ff, bq_in;
   logic [9:0]          brem_ff, brem_in;

   logic [AW-1:0]       rd_addr;
   logic                ld_we, bump_we, vld_clr, rsp_load;
   logic [AW-1:0]       ld_addr;
   logic signed [31:0]  bump_wdata;
   logic [8:0]          cnt9, n9, idx9;
   logic [NW-1:0]       n_used, n_last, idx_nx;
   logic signed [31:0]  bump_cur;
   logic signed [32:0]  rd_bumped;
   logic [23:0]         den_w;
   logic signed [33:0]  slope;
   logic signed [57:0]  qsum;
   logic signed [57:0]  bsum;
   logic [47:0]         dq_prod;
   logic [23:0]         dr_w;
   logic [34:0]         df_prod;
   logic [31:0]         dmag;
   logic                accept;

   bzci_pkg::div_req_type div_req;
   bzci_pkg::div_rsp_type div_rsp;

   bzci_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // clamp pillar count to 1..MAX_PILLARS
   always_comb begin
      cnt9 = {4'b0, count_ff};
      if (cnt9 == 9'd0) begin
         n9 = 9'd1;
      end else if (cnt9 > 9'(MAX_PILLARS)) begin
         n9 = 9'(MAX_PILLARS);
      end else begin
         n9 = cnt9;
      end
      n_used = n9[NW-1:0];
      n_last = n_used - 1'b1;
      idx_nx = idx_ff + 1'b1;
      idx9   = {5'b0, req_chan.pillar_index};
      ld_addr = idx9[AW-1:0];
   end

   assign bump_cur  = bvld_rd_ff ? bump_rd_ff : 32'sd0;
   assign rd_bumped = {zero_rd_ff[31], zero_rd_ff} + {bump_cur[31], bump_cur};
   assign accept    = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == bzci_pkg::ST_IDLE);

   // sequencer: next state and datapath
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      t_in          = t_ff;
      idx_in        = idx_ff;
      delta_in      = delta_ff;
      lo_t_in       = lo_t_ff;
      lo_v_in       = lo_v_ff;
      den_in        = den_ff;
      mcand_in      = mcand_ff;
      acc_in        = acc_ff;
      mplier_in     = mplier_ff;
      mcnt_in       = mcnt_ff;
      res_rate_in   = res_rate_ff;
      res_status_in = res_status_ff;
      bneg_in       = bneg_ff;
      bmag_in       = bmag_ff;
      bq_in         = bq_ff;
      brem_in       = brem_ff;
      rd_addr       = idx_ff[AW-1:0];
      ld_we         = 1'b0;
      bump_we       = 1'b0;
      vld_clr       = 1'b0;
      rsp_load      = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = acc_ff;
      div_req.divisor  = den_ff;
      den_w = {1'b0, tenor_rd_ff} - {1'b0, lo_t_ff};
      slope = {rd_bumped[32], rd_bumped} - {lo_v_ff[32], lo_v_ff};
      qsum  = {{25{lo_v_ff[32]}}, lo_v_ff} + {div_rsp.quotient[bzci_pkg::DIV_W-1], div_rsp.quotient};
      bsum  = {{26{bump_cur[31]}}, bump_cur} + {{26{delta_ff[31]}}, delta_ff};
      bump_wdata = bzci_pkg::sat32(bsum);
      dq_prod = {24'b0, bmag_ff} * {24'b0, bzci_pkg::BP_RECIP};
      dr_w    = bmag_ff - ({10'b0, bq_ff} * bzci_pkg::BP_BASE);
      df_prod = {25'b0, brem_ff} * {10'b0, bzci_pkg::BP_FRAC_RECIP};
      dmag    = {2'b0, bq_ff, df_prod[33:18]};
      case (state_ff)
         bzci_pkg::ST_IDLE: begin
            if (accept) begin
               op_in         = req_chan.opcode;
               t_in          = req_chan.time_point;
               idx_in        = '0;
               res_rate_in   = '0;
               res_status_in = bzci_pkg::STATUS_OK;
               case (req_chan.opcode)
                  bzci_pkg::OP_LOAD: begin
                     ld_we    = (idx9 < 9'(MAX_PILLARS));
                     state_in = bzci_pkg::ST_DONE;
                  end
                  bzci_pkg::OP_QUERY: begin
                     rd_addr  = '0;
                     state_in = bzci_pkg::ST_Q_FIRST;
                  end
                  bzci_pkg::OP_BUMP, bzci_pkg::OP_PAR: begin
                     bneg_in  = req_chan.bump_amount[23];
                     bmag_in  = req_chan.bump_amount[23] ?
                                (~$unsigned(req_chan.bump_amount) + 24'd1) :
                                $unsigned(req_chan.bump_amount);
                     state_in = bzci_pkg::ST_DELTA;
                  end
                  bzci_pkg::OP_CLEAR: begin
                     vld_clr  = 1'b1;
                     state_in = bzci_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = bzci_pkg::ST_DONE;
                  end
               endcase
            end
         end
         bzci_pkg::ST_Q_FIRST: begin
            lo_t_in = tenor_rd_ff;
            lo_v_in = rd_bumped;
            if (t_ff <= tenor_rd_ff) begin
               res_rate_in = bzci_pkg::sat32({{25{rd_bumped[32]}}, rd_bumped});
               state_in    = bzci_pkg::ST_DONE;
            end else begin
               rd_addr  = n_last[AW-1:0];
               state_in = bzci_pkg::ST_Q_LAST;
            end
         end
         bzci_pkg::ST_Q_LAST: begin
            if (t_ff >= tenor_rd_ff) begin
               res_rate_in = bzci_pkg::sat32({{25{rd_bumped[32]}}, rd_bumped});
               state_in    = bzci_pkg::ST_DONE;
            end else begin
               idx_in   = NW'(1);
               rd_addr  = AW'(1);
               state_in = bzci_pkg::ST_Q_SCAN;
            end
         end
         bzci_pkg::ST_Q_SCAN: begin
            if (tenor_rd_ff < t_ff) begin
               // advance the lower bracket
               lo_t_in = tenor_rd_ff;
               lo_v_in = rd_bumped;
               idx_in  = idx_nx;
               rd_addr = idx_nx[AW-1:0];
            end else if (den_w[23] || (den_w == 24'd0)) begin
               res_rate_in = bzci_pkg::sat32({{25{lo_v_ff[32]}}, lo_v_ff});
               state_in    = bzci_pkg::ST_DONE;
            end else begin
               den_in    = den_w[22:0];
               mcand_in  = {{23{slope[33]}}, slope};
               mplier_in = t_ff - lo_t_ff;
               acc_in    = '0;
               mcnt_in   = '0;
               state_in  = bzci_pkg::ST_MUL;
            end
         end
         bzci_pkg::ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            mcnt_in   = mcnt_ff + 1'b1;
            if (mcnt_ff == 5'(bzci_pkg::MUL_STEPS - 1)) begin
               state_in = bzci_pkg::ST_QDIV_GO;
            end
         end
         bzci_pkg::ST_QDIV_GO: begin
            div_req.start = 1'b1;
            state_in      = bzci_pkg::ST_QDIV;
         end
         bzci_pkg::ST_QDIV: begin
            if (div_rsp.done) begin
               res_rate_in = bzci_pkg::sat32(qsum);
               state_in    = bzci_pkg::ST_DONE;
            end
         end
         // scale the bump: whole multiples of 625 first
         bzci_pkg::ST_DELTA: begin
            bq_in    = dq_prod[46:33];
            state_in = bzci_pkg::ST_DREM;
         end
         bzci_pkg::ST_DREM: begin
            brem_in  = dr_w[9:0];
            state_in = bzci_pkg::ST_DSCALE;
         end
         // add the fractional part and restore the sign
         bzci_pkg::ST_DSCALE: begin
            delta_in = bneg_ff ? -$signed(dmag) : $signed(dmag);
            idx_in   = '0;
            state_in = bzci_pkg::ST_B_RD;
         end
         bzci_pkg::ST_B_RD: begin
            state_in = bzci_pkg::ST_B_CHK;
         end
         bzci_pkg::ST_B_CHK: begin
            if ((op_ff == bzci_pkg::OP_BUMP) && (tenor_rd_ff == t_ff)) begin
               bump_we  = 1'b1;
               state_in = bzci_pkg::ST_DONE;
            end else begin
               bump_we = (op_ff == bzci_pkg::OP_PAR);
               idx_in  = idx_nx;
               if (idx_nx == n_used) begin
                  if (op_ff == bzci_pkg::OP_BUMP) begin
                     res_status_in = bzci_pkg::STATUS_NO_MATCH;
                  end
                  state_in = bzci_pkg::ST_DONE;
               end else begin
                  state_in = bzci_pkg::ST_B_RD;
               end
            end
         end
         bzci_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = bzci_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bzci_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (ld_we) begin
         tenor_mem[ld_addr] <= req_chan.time_point;
         zero_mem[ld_addr]  <= req_chan.zero_value;
      end
      if (bump_we) begin
         bump_mem[idx_ff[AW-1:0]] <= bump_wdata;
      end
      tenor_rd_ff <= tenor_mem[rd_addr];
      zero_rd_ff  <= zero_mem[rd_addr];
      bump_rd_ff  <= bump_mem[rd_addr];
      bvld_rd_ff  <= bvld_ff[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bzci_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 5'd1;
         bvld_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         if (vld_clr) begin
            bvld_ff <= '0;
         end else if (bump_we) begin
            bvld_ff[idx_ff[AW-1:0]] <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      t_ff          <= t_in;
      idx_ff        <= idx_in;
      delta_ff      <= delta_in;
      lo_t_ff       <= lo_t_in;
      lo_v_ff       <= lo_v_in;
      den_ff        <= den_in;
      mcand_ff      <= mcand_in;
      acc_ff        <= acc_in;
      mplier_ff     <= mplier_in;
      mcnt_ff       <= mcnt_in;
      res_rate_ff   <= res_rate_in;
      res_status_ff <= res_status_in;
      bneg_ff       <= bneg_in;
      bmag_ff       <= bmag_in;
      bq_ff         <= bq_in;
      brem_ff       <= brem_in;
      if (rsp_load) begin
         rsp_rate_ff   <= res_rate_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.rate   = rsp_rate_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule

>>> rtl/core/bzci_checker.sv
module bzci_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_rate,
   input logic               rsp_status
);

   // hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rate) && $stable(rsp_status))
      else $error("rsp beat dropped or changed while stalled");

   // one item in flight: ready drops after an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   // no result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // a result never appears without an accepted request while the block is free
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result without work");

endmodule

bind bumped_zero_curve_interpolator bzci_checker u_bzci_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_rate   (rsp_chan.rate),
   .rsp_status (rsp_chan.status)
);

>>> bench/bzci_checker.sv
module bzci_scoreboard (
   input  logic   clock,
   input  logic   reset,
   input  logic   csr_we,
   input  logic [4:0] csr_wdata,
   bzci_req_if    req,
   bzci_rsp_if    rsp,
   output int     fail_count,
   output int     pending
);

   typedef struct {
      logic signed [31:0] rate;
      logic               status;
   } curve_answer_type;

   localparam int PILLARS = 16;

   logic [22:0]        tenor_mirror [PILLARS];
   logic signed [31:0] zero_mirror  [PILLARS];
   logic signed [31:0] bump_mirror  [PILLARS];
   logic [4:0]         count_mirror;
   curve_answer_type   answers_due [$];

   function automatic logic signed [31:0] clamp32(input longint v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic int pillars_in_use();
      int n;
      n = int'(count_mirror);
      if (n < 1) n = 1;
      if (n > PILLARS) n = PILLARS;
      return n;
   endfunction

   function automatic longint bumped_zero(input int i);
      return longint'(zero_mirror[i]) + longint'(bump_mirror[i]);
   endfunction

   // flat at both ends, linear between the bracketing pillars
   function automatic logic signed [31:0] rate_at(input logic [22:0] t);
      int     n;
      int     hi;
      int     lo;
      longint a;
      longint b;
      longint num;
      longint den;
      n = pillars_in_use();
      if (t <= tenor_mirror[0]) return clamp32(bumped_zero(0));
      if (t >= tenor_mirror[n-1]) return clamp32(bumped_zero(n-1));
      hi = 1;
      while (hi < n && tenor_mirror[hi] < t) hi++;
      if (hi >= n) hi = n - 1;
      lo = hi - 1;
      a = bumped_zero(lo);
      b = bumped_zero(hi);
      num = longint'(t) - longint'(tenor_mirror[lo]);
      den = longint'(tenor_mirror[hi]) - longint'(tenor_mirror[lo]);
      if (den <= 0) return clamp32(a);
      return clamp32(a + (num * (b - a)) / den);
   endfunction

   // apply one request beat to the mirrored curve and return its answer
   function automatic curve_answer_type apply_beat(input logic [2:0] op,
                                                   input logic [3:0] idx,
                                                   input logic [22:0] t,
                                                   input logic signed [31:0] z,
                                                   input logic signed [23:0] amt);
      curve_answer_type ans;
      longint           delta;
      int               n;
      delta = (longint'(amt) * 64'sd1048576) / 64'sd10000;
      n = pillars_in_use();
      ans.rate = '0;
      ans.status = bzci_pkg::STATUS_OK;
      case (op)
         bzci_pkg::OP_LOAD: begin
            tenor_mirror[idx] = t;
            zero_mirror[idx] = z;
         end
         bzci_pkg::OP_QUERY: begin
            ans.rate = rate_at(t);
         end
         bzci_pkg::OP_BUMP: begin
            ans.status = bzci_pkg::STATUS_NO_MATCH;
            for (int i = 0; i < n; i++) begin
               if (tenor_mirror[i] == t) begin
                  bump_mirror[i] = clamp32(longint'(bump_mirror[i]) + delta);
                  ans.status = bzci_pkg::STATUS_OK;
                  break;
               end
            end
         end
         bzci_pkg::OP_PAR: begin
            for (int i = 0; i < n; i++)
               bump_mirror[i] = clamp32(longint'(bump_mirror[i]) + delta);
         end
         bzci_pkg::OP_CLEAR: begin
            foreach (bump_mirror[i]) bump_mirror[i] = '0;
         end
         default: ;
      endcase
      return ans;
   endfunction

   // track register writes, predict on request beats, compare on response beats
   always @(posedge clock) begin
      curve_answer_type want;
      if (reset) begin
         foreach (bump_mirror[i]) bump_mirror[i] = '0;
         count_mirror <= 5'd1;
         answers_due.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (csr_we) count_mirror <= csr_wdata;
         if (req.valid && req.ready)
            answers_due.push_back(apply_beat(req.opcode, req.pillar_index, req.time_point,
                                             req.zero_value, req.bump_amount));
         if (rsp.valid && rsp.ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response beat rate=%0d status=%0d",
                        $time, rsp.rate, rsp.status);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (rsp.rate !== want.rate || rsp.status !== want.status) begin
                  $display("%0t: mismatch expected rate=%0d status=%0d, got rate=%0d status=%0d",
                           $time, want.rate, want.status, rsp.rate, rsp.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= answers_due.size();
      end
   end
endmodule

>>> bench/testbench.sv
module testbench;

   localparam int MAX_T      = 6553600;
   localparam int STALL_CAP  = 20000;
   localparam int DRAIN_WAIT = 300;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [4:0] csr_wdata;
   int         fail_count;
   int         pending;
   int         quiet_cycles;
   bit         send_busy_mode;
   bit         recv_busy_mode;
   logic [22:0] tenor_plan [16];

   bzci_req_if req_chan ();
   bzci_rsp_if rsp_chan ();

   bumped_zero_curve_interpolator u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   bzci_scoreboard u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // send one request beat after a random gap (in busy mode), hold until accepted
   task automatic send_beat(input logic [2:0] op, input logic [3:0] idx, input logic [22:0] t,
                            input logic signed [31:0] z, input logic signed [23:0] amt);
      int gap;
      gap = send_busy_mode ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.opcode       <= op;
      req_chan.pillar_index <= idx;
      req_chan.time_point   <= t;
      req_chan.zero_value   <= z;
      req_chan.bump_amount  <= amt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // drop valid and hold until every answer is back, then let the block settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_count(input logic [4:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // load all pillars with strictly increasing tenors and random zeros
   task automatic load_curve();
      int t;
      t = $urandom_range(0, 2000);
      for (int i = 0; i < 16; i++) begin
         tenor_plan[i] = 23'(t);
         send_beat(bzci_pkg::OP_LOAD, 4'(i), 23'(t), $urandom, 24'($urandom));
         t = t + int'($urandom_range(1, 400000));
      end
   endtask

   task automatic random_beat();
      int r;
      int k;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 15);
      if (r < 40) begin
         send_beat(bzci_pkg::OP_QUERY, 4'($urandom), 23'($urandom_range(0, MAX_T)), $urandom,
                   24'($urandom));
      end else if (r < 60) begin
         send_beat(bzci_pkg::OP_BUMP, 4'($urandom), tenor_plan[k], $urandom, 24'($urandom));
      end else if (r < 65) begin
         send_beat(bzci_pkg::OP_BUMP, 4'($urandom), 23'($urandom_range(0, MAX_T)), $urandom,
                   24'($urandom));
      end else if (r < 73) begin
         send_beat(bzci_pkg::OP_PAR, 4'($urandom), 23'($urandom_range(0, MAX_T)), $urandom,
                   24'($urandom));
      end else if (r < 78) begin
         send_beat(bzci_pkg::OP_CLEAR, 4'($urandom), 23'($urandom_range(0, MAX_T)), $urandom,
                   24'($urandom));
      end else if (r < 84) begin
         // reload a zero on the same tenor
         send_beat(bzci_pkg::OP_LOAD, 4'(k), tenor_plan[k], $urandom, 24'($urandom));
      end else if (r < 86) begin
         // out-of-order tenor
         tenor_plan[k] = 23'($urandom_range(0, MAX_T));
         send_beat(bzci_pkg::OP_LOAD, 4'(k), tenor_plan[k], $urandom, 24'($urandom));
      end else if (r < 91) begin
         send_beat(3'($urandom_range(5, 7)), 4'($urandom), 23'($urandom_range(0, MAX_T)),
                   $urandom, 24'($urandom));
      end else begin
         send_beat(bzci_pkg::OP_QUERY, 4'($urandom), 23'(tenor_plan[k] + $urandom_range(0, 1)),
                   $urandom, 24'($urandom));
      end
   endtask

   // response side: random stall before each beat in busy mode
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = recv_busy_mode ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_CAP) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [4:0] counts [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd16};
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      send_busy_mode = 1'b1;
      recv_busy_mode = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.opcode       = bzci_pkg::OP_LOAD;
      req_chan.pillar_index = '0;
      req_chan.time_point   = '0;
      req_chan.zero_value   = '0;
      req_chan.bump_amount  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full curve with extreme tenors and zeros
      write_count(5'd16);
      for (int i = 0; i < 16; i++) begin
         tenor_plan[i] = (i == 15) ? 23'(MAX_T) : 23'(i * 400000);
         send_beat(bzci_pkg::OP_LOAD, 4'(i), tenor_plan[i],
                   (i == 3) ? 32'sh7fffffff : (i == 4) ? 32'sh80000000 : 32'(i * 1000000),
                   24'sd0);
      end
      send_beat(bzci_pkg::OP_QUERY, 4'd0, 23'd0, '0, '0);
      send_beat(bzci_pkg::OP_QUERY, 4'd0, 23'(MAX_T), '0, '0);
      send_beat(bzci_pkg::OP_QUERY, 4'd0, 23'd1400000, '0, '0);
      send_beat(bzci_pkg::OP_QUERY, 4'd0, tenor_plan[7], '0, '0);
      send_beat(bzci_pkg::OP_BUMP, 4'd0, tenor_plan[3], '0, 24'sh7fffff);
      send_beat(bzci_pkg::OP_BUMP, 4'd0, 23'd7, '0, 24'sh800000);
      send_beat(bzci_pkg::OP_PAR, 4'd0, '0, '0, 24'sh7fffff);
      send_beat(bzci_pkg::OP_PAR, 4'd0, '0, '0, 24'sh7fffff);
      send_beat(bzci_pkg::OP_PAR, 4'd0, '0, '0, 24'sh7fffff);
      send_beat(bzci_pkg::OP_QUERY, 4'd0, 23'd1300000, '0, '0);
      send_beat(bzci_pkg::OP_PAR, 4'd0, '0, '0, 24'sh800000);
      send_beat(bzci_pkg::OP_CLEAR, 4'd0, '0, '0, '0);
      send_beat(3'd5, 4'hf, 23'h7fffff, 32'hffffffff, 24'hffffff);
      send_beat(3'd6, 4'd0, '0, '0, '0);
      send_beat(3'd7, 4'd0, '0, '0, '0);

      // random phases over several pillar counts
      for (int p = 0; p < 8; p++) begin
         write_count(counts[p]);
         send_busy_mode = (p % 3) != 1;
         recv_busy_mode = (p % 4) != 2;
         if (p % 2 == 1) load_curve();
         for (int j = 0; j < 120; j++) random_beat();
      end

      drain();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
